// ===== sv/assert_macros.svh =====
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define JSU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jsu assertion failed");

// condition that must never hold outside reset
`define JSU_NEVER(label, cond) \
  `JSU_ASSERT(label, !(cond))

`endif

// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

  // decoder phases
  typedef enum logic [3:0] {
    PH_TEXT    = 4'd0,
    PH_ESC     = 4'd1,
    PH_HEX1    = 4'd2,
    PH_WANT_BS = 4'd3,
    PH_WANT_U  = 4'd4,
    PH_HEX2    = 4'd5,
    PH_DONE    = 4'd6
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // surrogate tags in the top six bits of a code unit
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one queued command: a single result or a code point to encode
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  len_m1;
    logic [20:0] cp;
  } cmd_t;

  // front to queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // queue to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // hex digit decode: {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // utf-8 length minus one of a code point
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // byte number idx of a command's output sequence
  function automatic logic [7:0] utf8_byte(input cmd_t cmd, input logic [1:0] idx);
    logic [7:0] r;
    logic [1:0] rem;
    rem = cmd.len_m1 - idx;
    r = 8'd0;
    if (idx == 2'd0) begin
      unique case (cmd.len_m1)
        2'd0:    r = cmd.cp[7:0];
        2'd1:    r = {3'b110, cmd.cp[10:6]};
        2'd2:    r = {4'b1110, cmd.cp[15:12]};
        default: r = {5'b11110, cmd.cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    r = {2'b10, cmd.cp[5:0]};
        2'd1:    r = {2'b10, cmd.cp[11:6]};
        2'd2:    r = {2'b10, cmd.cp[17:12]};
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== sv/jsu_stream_if.sv =====
// raw byte channel
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink (input valid, input in_byte, input restart, output ready);
endinterface

// decoded result channel
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== sv/jsu_front.sv =====
module jsu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsu_in_if.sink         in_i,
  input  logic           queue_full_i,
  output jsu_pkg::push_t push_o
);

  jsu_pkg::phase_e phase_q, phase_d, ph_eff;
  logic [1:0]  digit_q, digit_d, digit_eff;
  logic [15:0] code_q, code_d, code_eff;
  logic [15:0] high_q, high_d, high_eff;
  logic [4:0]  hx;
  logic [15:0] code_next;
  logic        digit_last;
  logic        is_low;
  logic        is_high;
  logic        accept;
  logic [20:0] pair_cp;
  logic [7:0]  c;

  // accept a request whenever the queue has room
  assign in_i.ready = !queue_full_i;
  assign accept     = in_i.valid && !queue_full_i;
  assign c          = in_i.in_byte;

  // restart clears the state seen by this request
  assign ph_eff    = in_i.restart ? jsu_pkg::PH_TEXT : phase_q;
  assign digit_eff = in_i.restart ? 2'd0 : digit_q;
  assign code_eff  = in_i.restart ? 16'd0 : code_q;
  assign high_eff  = in_i.restart ? 16'd0 : high_q;

  // hex digit gathering and surrogate classification
  assign hx         = jsu_pkg::hex_decode(c);
  assign code_next  = {code_eff[11:0], hx[3:0]};
  assign digit_last = (digit_eff == 2'd3);
  assign is_low     = (code_next[15:10] == jsu_pkg::SURR_LOW);
  assign is_high    = (code_next[15:10] == jsu_pkg::SURR_HIGH);
  assign pair_cp    = jsu_pkg::SUPP_BASE + {1'b0, high_eff[9:0], code_next[9:0]};

  // next state
  always_comb begin
    phase_d = ph_eff;
    digit_d = digit_eff;
    code_d  = code_eff;
    high_d  = high_eff;
    unique case (ph_eff)
      jsu_pkg::PH_TEXT: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          phase_d = jsu_pkg::PH_DONE;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          phase_d = jsu_pkg::PH_ESC;
        end
      end
      jsu_pkg::PH_ESC: begin
        unique case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
          jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
          jsu_pkg::CH_R, jsu_pkg::CH_T: phase_d = jsu_pkg::PH_TEXT;
          jsu_pkg::CH_U: begin
            phase_d = jsu_pkg::PH_HEX1;
            digit_d = 2'd0;
            code_d  = 16'd0;
          end
          default: phase_d = jsu_pkg::PH_DONE;
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (!hx[4]) begin
          phase_d = jsu_pkg::PH_DONE;
        end else begin
          code_d  = code_next;
          digit_d = digit_last ? 2'd0 : digit_eff + 2'd1;
          if (digit_last) begin
            if (ph_eff == jsu_pkg::PH_HEX1) begin
              if (is_low) begin
                phase_d = jsu_pkg::PH_DONE;
              end else if (is_high) begin
                high_d  = code_next;
                phase_d = jsu_pkg::PH_WANT_BS;
              end else begin
                phase_d = jsu_pkg::PH_TEXT;
              end
            end else begin
              phase_d = is_low ? jsu_pkg::PH_TEXT : jsu_pkg::PH_DONE;
            end
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        phase_d = (c == jsu_pkg::CH_BSLASH) ? jsu_pkg::PH_WANT_U : jsu_pkg::PH_DONE;
      end
      jsu_pkg::PH_WANT_U: begin
        if (c == jsu_pkg::CH_U) begin
          phase_d = jsu_pkg::PH_HEX2;
          digit_d = 2'd0;
          code_d  = 16'd0;
        end else begin
          phase_d = jsu_pkg::PH_DONE;
        end
      end
      default: phase_d = ph_eff;
    endcase
  end

  // command pushed to the queue
  always_comb begin
    push_o.valid      = 1'b0;
    push_o.cmd.kind   = jsu_pkg::KIND_BYTE;
    push_o.cmd.len_m1 = 2'd0;
    push_o.cmd.cp     = {13'd0, c};
    unique case (ph_eff)
      jsu_pkg::PH_TEXT: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          push_o.valid    = 1'b1;
          push_o.cmd.kind = jsu_pkg::KIND_END;
          push_o.cmd.cp   = 21'd0;
        end else if (c != jsu_pkg::CH_BSLASH) begin
          push_o.valid = 1'b1;
        end
      end
      jsu_pkg::PH_ESC: begin
        push_o.valid = 1'b1;
        unique case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: ;
          jsu_pkg::CH_B: push_o.cmd.cp = {13'd0, jsu_pkg::CTL_BS};
          jsu_pkg::CH_F: push_o.cmd.cp = {13'd0, jsu_pkg::CTL_FF};
          jsu_pkg::CH_N: push_o.cmd.cp = {13'd0, jsu_pkg::CTL_LF};
          jsu_pkg::CH_R: push_o.cmd.cp = {13'd0, jsu_pkg::CTL_CR};
          jsu_pkg::CH_T: push_o.cmd.cp = {13'd0, jsu_pkg::CTL_TAB};
          jsu_pkg::CH_U: push_o.valid = 1'b0;
          default: begin
            push_o.cmd.kind = jsu_pkg::KIND_ERROR;
            push_o.cmd.cp   = 21'd0;
          end
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (!hx[4]) begin
          push_o.valid    = 1'b1;
          push_o.cmd.kind = jsu_pkg::KIND_ERROR;
          push_o.cmd.cp   = 21'd0;
        end else if (digit_last) begin
          push_o.valid = !(ph_eff == jsu_pkg::PH_HEX1 && is_high);
          if ((ph_eff == jsu_pkg::PH_HEX1) ? is_low : !is_low) begin
            push_o.cmd.kind = jsu_pkg::KIND_ERROR;
            push_o.cmd.cp   = 21'd0;
          end else if (ph_eff == jsu_pkg::PH_HEX1) begin
            push_o.cmd.cp     = {5'd0, code_next};
            push_o.cmd.len_m1 = jsu_pkg::utf8_len_m1({5'd0, code_next});
          end else begin
            push_o.cmd.cp     = pair_cp;
            push_o.cmd.len_m1 = jsu_pkg::utf8_len_m1(pair_cp);
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (c != jsu_pkg::CH_BSLASH) begin
          push_o.valid    = 1'b1;
          push_o.cmd.kind = jsu_pkg::KIND_ERROR;
          push_o.cmd.cp   = 21'd0;
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (c != jsu_pkg::CH_U) begin
          push_o.valid    = 1'b1;
          push_o.cmd.kind = jsu_pkg::KIND_ERROR;
          push_o.cmd.cp   = 21'd0;
        end
      end
      default: push_o.valid = 1'b0;
    endcase
    push_o.valid = push_o.valid && accept;
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_TEXT;
      digit_q <= 2'd0;
      code_q  <= 16'd0;
      high_q  <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
      code_q  <= code_d;
      high_q  <= high_d;
    end
  end

endmodule

// ===== sv/jsu_queue.sv =====
module jsu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsu_pkg::push_t push_i,
  output logic           full_o,
  output jsu_pkg::head_t head_o,
  input  logic           pop_i
);

  jsu_pkg::cmd_t mem_q [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::QUEUE_CNT_W-1:0] count_q;
  logic push;
  logic pop;

  assign full_o      = (count_q == jsu_pkg::QUEUE_CNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign push        = push_i.valid && !full_o;
  assign pop         = pop_i && head_o.valid;

  // command storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == jsu_pkg::QUEUE_PTR_W'(jsu_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == jsu_pkg::QUEUE_PTR_W'(jsu_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/jsu_back.sv =====
module jsu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsu_pkg::head_t head_i,
  output logic           pop_o,
  jsu_out_if.source      out_o
);

  logic [1:0] idx_q;
  logic       load;
  logic       at_last;
  logic       valid_q;
  logic [7:0] byte_q;
  logic [1:0] kind_q;
  logic       last_q;

  // load the output register when it is empty or being taken
  assign load    = head_i.valid && (!valid_q || out_o.ready);
  assign at_last = (idx_q == head_i.cmd.len_m1);
  assign pop_o   = load && at_last;

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.kind     = kind_q;
  assign out_o.last     = last_q;

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= jsu_pkg::utf8_byte(head_i.cmd, idx_q);
      kind_q <= head_i.cmd.kind;
      last_q <= at_last;
    end
  end

  // byte position within the command and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/json_string_unescape.sv =====
// json string unescape: one raw byte accepted per cycle when the command queue has room
// a byte's results pass through the command queue and then the output register, waiting in either under back-pressure
// throughput: one result per cycle while the output is ready; a \u escape giving n utf-8 bytes sends them in turn
// bytes that give no result (backslash, early hex digits) are accepted without pushing a command
// reset: asynchronous active low, clears decoder phase, queue pointers and output valid
module json_string_unescape (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  `include "assert_macros.svh"

  jsu_pkg::push_t push;
  jsu_pkg::head_t head;
  logic           queue_full;
  logic           pop;

  // front: accepts and classifies raw bytes
  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  // command queue
  jsu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: expands commands into result bytes
  jsu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // checks
  `JSU_NEVER(a_no_push_when_full, push.valid && queue_full)
  `JSU_ASSERT(a_end_error_single, (out_o.valid && out_o.kind != jsu_pkg::KIND_BYTE) |-> (out_o.last && out_o.out_byte == 8'd0))
  `JSU_ASSERT(a_out_from_queue, $rose(out_o.valid) |-> $past(head.valid))

endmodule

// ===== bench/json_string_unescape_tb.sv =====
module json_string_unescape_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 200;
  localparam int WATCHDOG = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS = 10;

  // the eight single-byte escape letters
  localparam logic [63:0] ESC_SET = {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                     jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                     jsu_pkg::CH_F, jsu_pkg::CH_N,
                                     jsu_pkg::CH_R, jsu_pkg::CH_T};

  // how a request's results are known
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_ONE
  } chk_e;

  typedef struct packed {
    logic [7:0]     in_byte;
    logic           restart;
    chk_e           chk;
    jsu_pkg::kind_e t_kind;
    logic [7:0]     t_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]     out_byte;
    jsu_pkg::kind_e kind;
    logic           last;
  } dec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // directed requests: extremes, escapes, code point zero, a full-range pair,
  // end of string, bytes after the end, an unknown escape
  req_t dir_rows [27] = '{
    '{8'h41,              1'b1, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'h41},
    '{8'h00,              1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'h00},
    '{8'hFF,              1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'hFF},
    '{jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_U,      1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",                1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_T,      1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  jsu_pkg::CTL_TAB},
    '{jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_U,      1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"d",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"b",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"f",                1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_U,      1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"D",                1'b0, CHK_PRED, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",                1'b0, CHK_PRED, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",                1'b0, CHK_PRED, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",                1'b0, CHK_PRED, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_QUOTE,  1'b0, CHK_ONE,  jsu_pkg::KIND_END,   8'h00},
    '{jsu_pkg::CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{jsu_pkg::CH_BSLASH, 1'b1, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"q",                1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00}
  };

  req_t     stim_q [$];
  req_t     cur_req;
  dec_res_t decoded_q [$];
  dec_res_t step_res [$];

  int   n_in = 0;
  int   n_total;
  int   n_live;
  int   n_fail = 0;
  int   idle_cycles = 0;
  logic rs_pending;

  // decoder state mirror
  jsu_pkg::phase_e dec_phase = jsu_pkg::PH_TEXT;
  logic [1:0]      dig_cnt   = 2'd0;
  logic [15:0]     unit_acc  = 16'd0;
  logic [15:0]     high_acc  = 16'd0;

  wire calm = (n_in >= 150 && n_in < 230);

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'("0");
    end else if (c >= "a" && c <= "f") begin
      return int'(c) - int'("a") + 10;
    end else if (c >= "A" && c <= "F") begin
      return int'(c) - int'("A") + 10;
    end
    return -1;
  endfunction

  // shift in one hex digit, true once the unit is complete
  function automatic bit shift_digit(input logic [3:0] v);
    unit_acc = {unit_acc[11:0], v};
    if (dig_cnt == 2'd3) begin
      dig_cnt = 2'd0;
      return 1'b1;
    end
    dig_cnt = dig_cnt + 2'd1;
    return 1'b0;
  endfunction

  task automatic put_res(input logic [7:0] b, input jsu_pkg::kind_e k);
    dec_res_t r;
    r.out_byte = b;
    r.kind     = k;
    r.last     = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic raise_error();
    dec_phase = jsu_pkg::PH_DONE;
    put_res(8'h00, jsu_pkg::KIND_ERROR);
  endtask

  // utf-8 encoding of one code point
  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_res(cp[7:0], jsu_pkg::KIND_BYTE);
    end else if (cp < 21'h800) begin
      put_res({3'b110, cp[10:6]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end else if (cp < 21'h10000) begin
      put_res({4'b1110, cp[15:12]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end else begin
      put_res({5'b11110, cp[20:18]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[17:12]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[11:6]}, jsu_pkg::KIND_BYTE);
      put_res({2'b10, cp[5:0]}, jsu_pkg::KIND_BYTE);
    end
  endtask

  // decode one raw byte into step_res
  task automatic unescape_step(input logic [7:0] c, input logic rs);
    int v;
    step_res.delete();
    if (rs) begin
      dec_phase = jsu_pkg::PH_TEXT;
      dig_cnt   = 2'd0;
      unit_acc  = 16'd0;
      high_acc  = 16'd0;
    end
    case (dec_phase)
      jsu_pkg::PH_TEXT: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          dec_phase = jsu_pkg::PH_DONE;
          put_res(8'h00, jsu_pkg::KIND_END);
        end else if (c == jsu_pkg::CH_BSLASH) begin
          dec_phase = jsu_pkg::PH_ESC;
        end else begin
          put_res(c, jsu_pkg::KIND_BYTE);
        end
      end
      jsu_pkg::PH_ESC: begin
        dec_phase = jsu_pkg::PH_TEXT;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            put_res(c, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_B: put_res(jsu_pkg::CTL_BS, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_F: put_res(jsu_pkg::CTL_FF, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_N: put_res(jsu_pkg::CTL_LF, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_R: put_res(jsu_pkg::CTL_CR, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_T: put_res(jsu_pkg::CTL_TAB, jsu_pkg::KIND_BYTE);
          jsu_pkg::CH_U: begin
            dec_phase = jsu_pkg::PH_HEX1;
            dig_cnt   = 2'd0;
            unit_acc  = 16'd0;
          end
          default: raise_error();
        endcase
      end
      jsu_pkg::PH_HEX1: begin
        v = hex_val(c);
        if (v < 0) begin
          raise_error();
        end else if (shift_digit(v[3:0])) begin
          if (unit_acc[15:10] == jsu_pkg::SURR_LOW) begin
            raise_error();
          end else if (unit_acc[15:10] == jsu_pkg::SURR_HIGH) begin
            high_acc  = unit_acc;
            dec_phase = jsu_pkg::PH_WANT_BS;
          end else begin
            dec_phase = jsu_pkg::PH_TEXT;
            put_code_point({5'd0, unit_acc});
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (c != jsu_pkg::CH_BSLASH) begin
          raise_error();
        end else begin
          dec_phase = jsu_pkg::PH_WANT_U;
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (c != jsu_pkg::CH_U) begin
          raise_error();
        end else begin
          dec_phase = jsu_pkg::PH_HEX2;
          dig_cnt   = 2'd0;
          unit_acc  = 16'd0;
        end
      end
      jsu_pkg::PH_HEX2: begin
        v = hex_val(c);
        if (v < 0) begin
          raise_error();
        end else if (shift_digit(v[3:0])) begin
          if (unit_acc[15:10] != jsu_pkg::SURR_LOW) begin
            raise_error();
          end else begin
            dec_phase = jsu_pkg::PH_TEXT;
            put_code_point(jsu_pkg::SUPP_BASE + {1'b0, high_acc[9:0], unit_acc[9:0]});
          end
        end
      end
      default: ;
    endcase
    if (step_res.size() != 0) begin
      step_res[step_res.size() - 1].last = 1'b1;
    end
  endtask

  // random hex digit character, letters in either case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'("0") + 8'(v);
    end
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
  endfunction

  task automatic add_req(input logic [7:0] b);
    req_t r;
    r.in_byte  = b;
    r.restart  = rs_pending;
    r.chk      = CHK_PRED;
    r.t_kind   = jsu_pkg::KIND_BYTE;
    r.t_byte   = 8'h00;
    rs_pending = 1'b0;
    n_live++;
    stim_q.push_back(r);
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_req(jsu_pkg::CH_BSLASH);
    add_req(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) begin
      add_req(hex_char(u[4 * i +: 4]));
    end
  endtask

  // one string body: mostly well formed, sometimes cut short or broken
  task automatic build_string();
    int          nseg;
    int          pick;
    int          k;
    bit          broke;
    bit          known;
    logic [7:0]  b;
    logic [15:0] u;
    logic [15:0] hi;
    req_t        r;
    rs_pending = 1'b1;
    broke      = 1'b0;
    nseg       = $urandom_range(1, 8);
    for (int s = 0; s < nseg && !broke; s++) begin
      pick = $urandom_range(0, 99);
      hi   = {jsu_pkg::SURR_HIGH, 10'($urandom)};
      if (pick < 40) begin
        do b = 8'($urandom_range(0, 255));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        add_req(b);
      end else if (pick < 60) begin
        add_req(jsu_pkg::CH_BSLASH);
        add_req(ESC_SET[8 * $urandom_range(0, 7) +: 8]);
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: u = 16'($urandom_range(0, 'h7F));
          1: u = 16'($urandom_range('h80, 'h7FF));
          default: begin
            do u = 16'($urandom_range('h800, 'hFFFF)); while (u[15:11] == 5'b11011);
          end
        endcase
        add_unit(u);
      end else if (pick < 87) begin
        add_unit(hi);
        add_unit({jsu_pkg::SURR_LOW, 10'($urandom)});
      end else if (pick < 91) begin
        // escape cut short, the next byte restarts the string
        add_req(jsu_pkg::CH_BSLASH);
        k = $urandom_range(0, 4);
        if (k > 0) begin
          add_req(jsu_pkg::CH_U);
        end
        for (int i = 1; i < k; i++) begin
          add_req(hex_char(4'($urandom)));
        end
        rs_pending = 1'b1;
      end else begin
        broke = 1'b1;
        case ($urandom_range(0, 5))
          // bad hex digit, a quote among them
          0: begin
            add_req(jsu_pkg::CH_BSLASH);
            add_req(jsu_pkg::CH_U);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) begin
              add_req(hex_char(4'($urandom)));
            end
            if ($urandom_range(0, 3) == 0) begin
              b = jsu_pkg::CH_QUOTE;
            end else begin
              do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
            end
            add_req(b);
          end
          // lone low surrogate
          1: add_unit({jsu_pkg::SURR_LOW, 10'($urandom)});
          // high surrogate not followed by a backslash
          2: begin
            add_unit(hi);
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_BSLASH);
            add_req(b);
          end
          // high surrogate, backslash, then not u
          3: begin
            add_unit(hi);
            add_req(jsu_pkg::CH_BSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_U);
            add_req(b);
          end
          // high surrogate followed by a unit that is not a low one
          4: begin
            add_unit(hi);
            do u = 16'($urandom_range(0, 'hFFFF)); while (u[15:10] == jsu_pkg::SURR_LOW);
            add_unit(u);
          end
          // unknown escape letter
          default: begin
            add_req(jsu_pkg::CH_BSLASH);
            do begin
              b     = 8'($urandom_range(0, 255));
              known = (b == jsu_pkg::CH_U);
              for (int i = 0; i < 8; i++) begin
                if (ESC_SET[8 * i +: 8] == b) begin
                  known = 1'b1;
                end
              end
            end while (known);
            add_req(b);
          end
        endcase
      end
    end
    if (!broke && $urandom_range(0, 9) != 0) begin
      add_req(jsu_pkg::CH_QUOTE);
    end
    // trailing bytes, dropped once the string has ended
    repeat ($urandom_range(0, 2)) begin
      r         = '0;
      r.in_byte = 8'($urandom_range(0, 255));
      r.chk     = CHK_PRED;
      stim_q.push_back(r);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_req
    req_t nxt;
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'h00;
      in_ch.restart <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        nxt = stim_q.pop_front();
        cur_req         <= nxt;
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= nxt.in_byte;
        in_ch.restart   <= nxt.restart;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // predict on accepted requests, check accepted results, watchdog
  always @(posedge clk_i) begin : track
    dec_res_t want;
    logic     moved;
    moved = 1'b0;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      moved = 1'b1;
      n_in++;
      unescape_step(in_ch.in_byte, in_ch.restart);
      case (cur_req.chk)
        CHK_PRED: begin
          foreach (step_res[i]) begin
            decoded_q.push_back(step_res[i]);
          end
        end
        CHK_ONE: begin
          want.out_byte = cur_req.t_byte;
          want.kind     = cur_req.t_kind;
          want.last     = 1'b1;
          decoded_q.push_back(want);
        end
        default: ;
      endcase
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      if (decoded_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
          $display("unexpected result: byte %02h kind %0d last %0b",
                   out_ch.out_byte, out_ch.kind, out_ch.last);
        end
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte || out_ch.kind !== want.kind ||
            out_ch.last !== want.last) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("result mismatch: expected byte %02h kind %0d last %0b,",
                     want.out_byte, want.kind, want.last,
                     " got byte %02h kind %0d last %0b",
                     out_ch.out_byte, out_ch.kind, out_ch.last);
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles == WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    n_live     = 0;
    rs_pending = 1'b0;

    // directed table first, then random strings
    foreach (dir_rows[i]) begin
      stim_q.push_back(dir_rows[i]);
    end
    while (n_live < N_RANDOM) begin
      build_string();
    end
    n_total = stim_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in != n_total) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
